// ===== rtl/jpd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jpd_pkg
// Shared types, joint tables and register codes of the joint PD drive.
// ----------------------------------------------------------------------------
package jpd_pkg;

	// configuration register indexes
	localparam logic [1:0] REG_VISCOUS  = 2'd0;
	localparam logic [1:0] REG_ACCEL    = 2'd1;
	localparam logic [1:0] REG_TSTEP    = 2'd2;

	localparam logic [31:0] VISCOUS_RST = 32'd19661;
	localparam logic [31:0] ACCEL_RST   = 32'd85899346;
	localparam logic [31:0] TSTEP_RST   = 32'd4294967;

	localparam logic [2:0] MODE_ACTIVE = 3'd4;
	localparam logic [2:0] MODE_IDLE   = 3'd3;

	localparam logic signed [31:0] Q_TAU_SMALL  = 32'sd1507328;
	localparam logic signed [31:0] Q_TAU_LARGE  = 32'sd3604480;
	localparam logic signed [31:0] Q_ABAD_LIM   = 32'sd43464;
	localparam logic signed [31:0] Q_THIGH_LIM  = 32'sd171573;
	localparam logic signed [31:0] Q_CALF_LIM   = 32'sd165806;
	localparam logic signed [31:0] Q_THIGH_INIT = 32'sd98304;
	localparam logic signed [31:0] Q_OFF_SMALL  = 32'sd3277;
	localparam logic signed [31:0] Q_OFF_HALF   = 32'sd32768;
	localparam logic signed [31:0] Q_OFF_KNEE   = 32'sd76677;

	typedef enum logic [1:0] {
		KIND_ABAD,
		KIND_THIGH,
		KIND_CALF
	} kind_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_PHW,
		ST_EP,
		ST_MKP,
		ST_TKP,
		ST_MKD,
		ST_TKD,
		ST_FF,
		ST_CLP,
		ST_MV,
		ST_NET,
		ST_MA,
		ST_VEL,
		ST_MT,
		ST_POS,
		ST_LIM,
		ST_OUT
	} state_t;

	typedef enum logic [2:0] {
		MUL_KP,
		MUL_KD,
		MUL_VISC,
		MUL_ASG,
		MUL_TS
	} mul_op_t;

	typedef enum logic [3:0] {
		ADD_NONE,
		ADD_PHW,
		ADD_EP,
		ADD_EV,
		ADD_TKD,
		ADD_FF,
		ADD_NET,
		ADD_VEL,
		ADD_POS,
		ADD_OUT
	} add_op_t;

	typedef struct packed {
		logic    mul_en;
		mul_op_t mul_op;
		add_op_t add_op;
		logic    acc_load;
		logic    clamp_tau;
		logic    clamp_pos;
		logic    idle;
		logic    finish;
	} ctl_t;

	typedef struct packed {
		logic start;
		logic cmd_valid;
		logic in_range;
		logic out_free;
	} sts_t;

	function automatic kind_t kind_of(input logic [3:0] j);
		kind_t k;
		case (j)
			4'd0, 4'd3, 4'd6, 4'd9, 4'd12, 4'd15: k = KIND_ABAD;
			4'd1, 4'd4, 4'd7, 4'd10, 4'd13:       k = KIND_THIGH;
			default:                              k = KIND_CALF;
		endcase
		return k;
	endfunction

	function automatic logic [3:0] slot_of(input logic [3:0] j);
		logic [3:0] s;
		case (j)
			4'd0:    s = 4'd0;
			4'd1:    s = 4'd1;
			4'd2:    s = 4'd2;
			4'd3:    s = 4'd4;
			4'd4:    s = 4'd5;
			4'd5:    s = 4'd6;
			4'd6:    s = 4'd8;
			4'd7:    s = 4'd9;
			4'd8:    s = 4'd10;
			4'd9:    s = 4'd12;
			4'd10:   s = 4'd13;
			4'd11:   s = 4'd14;
			4'd12:   s = 4'd3;
			4'd13:   s = 4'd7;
			4'd14:   s = 4'd11;
			default: s = 4'd15;
		endcase
		return s;
	endfunction

	function automatic logic signed [31:0] slot_offset(input logic [3:0] s);
		logic signed [31:0] o;
		case (s)
			4'd0, 4'd8:   o = -Q_OFF_SMALL;
			4'd4, 4'd12:  o = Q_OFF_SMALL;
			4'd1, 4'd5:   o = -Q_OFF_HALF;
			4'd9, 4'd13:  o = Q_OFF_HALF;
			4'd2, 4'd6:   o = Q_OFF_KNEE;
			4'd10, 4'd14: o = -Q_OFF_KNEE;
			default:      o = '0;
		endcase
		return o;
	endfunction

	function automatic logic signed [31:0] kind_lim(input kind_t k);
		logic signed [31:0] v;
		case (k)
			KIND_ABAD:  v = Q_ABAD_LIM;
			KIND_THIGH: v = Q_THIGH_LIM;
			default:    v = Q_CALF_LIM;
		endcase
		return v;
	endfunction

	function automatic logic signed [31:0] kind_tau(input kind_t k);
		logic signed [31:0] v;
		case (k)
			KIND_CALF: v = Q_TAU_LARGE;
			default:   v = Q_TAU_SMALL;
		endcase
		return v;
	endfunction

	function automatic logic signed [31:0] kind_init(input kind_t k);
		logic signed [31:0] v;
		case (k)
			KIND_THIGH: v = Q_THIGH_INIT;
			KIND_CALF:  v = -Q_CALF_LIM;
			default:    v = '0;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/jpd_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jpd_in_if
// Command channel: one joint tick request per item.
// ----------------------------------------------------------------------------
interface jpd_in_if;
	logic               valid;
	logic               ready;
	logic [3:0]         joint;
	logic               cmd_valid;
	logic signed [31:0] target_pos;
	logic signed [31:0] target_vel;
	logic signed [31:0] torque_ff;
	logic [31:0]        prop_gain;
	logic [31:0]        deriv_gain;

	modport source (
		output valid, joint, cmd_valid, target_pos, target_vel, torque_ff,
			prop_gain, deriv_gain,
		input  ready
	);
	modport sink (
		input  valid, joint, cmd_valid, target_pos, target_vel, torque_ff,
			prop_gain, deriv_gain,
		output ready
	);
endinterface

// ===== rtl/jpd_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jpd_out_if
// Result channel: joint state after one tick.
// ----------------------------------------------------------------------------
interface jpd_out_if;
	logic               valid;
	logic               ready;
	logic [3:0]         hw_slot;
	logic [2:0]         motor_mode;
	logic signed [31:0] pos_hw;
	logic signed [31:0] vel_out;
	logic signed [31:0] torque_applied;

	modport source (
		output valid, hw_slot, motor_mode, pos_hw, vel_out, torque_applied,
		input  ready
	);
	modport sink (
		input  valid, hw_slot, motor_mode, pos_hw, vel_out, torque_applied,
		output ready
	);
endinterface

// ===== rtl/jpd_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jpd_alu
// Shared arithmetic unit: registered signed-by-unsigned multiplier and a
// wide add/subtract with 32-bit saturation.
// ----------------------------------------------------------------------------
module jpd_alu (
	input  logic               clk,
	input  logic               mul_en,
	input  logic signed [31:0] mul_a,
	input  logic [31:0]        mul_b,
	input  logic signed [63:0] add_a,
	input  logic signed [63:0] add_b,
	input  logic               sub,
	output logic signed [63:0] prod,
	output logic signed [64:0] sum,
	output logic signed [31:0] sum_sat
);

	localparam logic signed [64:0] SAT_MAX = 65'sd2147483647;
	localparam logic signed [64:0] SAT_MIN = -65'sd2147483648;

	logic signed [32:0] mul_b_ext;
	logic signed [65:0] prod_full;
	logic signed [63:0] prod_q;
	logic signed [64:0] a_ext;
	logic signed [64:0] b_ext;

	assign mul_b_ext = $signed({1'b0, mul_b});
	assign prod_full = {{34{mul_a[31]}}, mul_a} * {{33{mul_b_ext[32]}}, mul_b_ext};

	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_q <= prod_full[63:0];
		end
	end

	assign prod  = prod_q;
	assign a_ext = {add_a[63], add_a};
	assign b_ext = {add_b[63], add_b};

	always_comb begin
		if (sub) begin
			sum = a_ext - b_ext;
		end else begin
			sum = a_ext + b_ext;
		end
		if (sum > SAT_MAX) begin
			sum_sat = 32'sh7fffffff;
		end else if (sum < SAT_MIN) begin
			sum_sat = 32'sh80000000;
		end else begin
			sum_sat = sum[31:0];
		end
	end

endmodule

// ===== rtl/jpd_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jpd_ctrl
// Sequencer that steps the shared unit through the PD law and the plant.
// ----------------------------------------------------------------------------
module jpd_ctrl
	import jpd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  sts_t sts,
	output ctl_t ctl
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		ctl.mul_en    = 1'b0;
		ctl.mul_op    = MUL_KP;
		ctl.add_op    = ADD_NONE;
		ctl.acc_load  = 1'b0;
		ctl.clamp_tau = 1'b0;
		ctl.clamp_pos = 1'b0;
		ctl.idle      = 1'b0;
		ctl.finish    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				ctl.idle = 1'b1;
				if (sts.start) begin
					if (!sts.in_range) begin
						state_d = ST_OUT;
					end else if (sts.cmd_valid) begin
						state_d = ST_PHW;
					end else begin
						state_d = ST_MV;
					end
				end
			end
			ST_PHW: begin
				ctl.add_op = ADD_PHW;
				state_d    = ST_EP;
			end
			ST_EP: begin
				ctl.add_op = ADD_EP;
				state_d    = ST_MKP;
			end
			ST_MKP: begin
				ctl.mul_en = 1'b1;
				ctl.mul_op = MUL_KP;
				state_d    = ST_TKP;
			end
			// kp term into the accumulator while the velocity error forms
			ST_TKP: begin
				ctl.acc_load = 1'b1;
				ctl.add_op   = ADD_EV;
				state_d      = ST_MKD;
			end
			ST_MKD: begin
				ctl.mul_en = 1'b1;
				ctl.mul_op = MUL_KD;
				state_d    = ST_TKD;
			end
			ST_TKD: begin
				ctl.add_op = ADD_TKD;
				state_d    = ST_FF;
			end
			ST_FF: begin
				ctl.add_op = ADD_FF;
				state_d    = ST_CLP;
			end
			// damping product starts alongside the torque clamp
			ST_CLP: begin
				ctl.clamp_tau = 1'b1;
				ctl.mul_en    = 1'b1;
				ctl.mul_op    = MUL_VISC;
				state_d       = ST_NET;
			end
			ST_MV: begin
				ctl.mul_en = 1'b1;
				ctl.mul_op = MUL_VISC;
				state_d    = ST_NET;
			end
			ST_NET: begin
				ctl.add_op = ADD_NET;
				state_d    = ST_MA;
			end
			ST_MA: begin
				ctl.mul_en = 1'b1;
				ctl.mul_op = MUL_ASG;
				state_d    = ST_VEL;
			end
			ST_VEL: begin
				ctl.add_op = ADD_VEL;
				state_d    = ST_MT;
			end
			ST_MT: begin
				ctl.mul_en = 1'b1;
				ctl.mul_op = MUL_TS;
				state_d    = ST_POS;
			end
			ST_POS: begin
				ctl.add_op = ADD_POS;
				state_d    = ST_LIM;
			end
			ST_LIM: begin
				ctl.clamp_pos = 1'b1;
				state_d       = ST_OUT;
			end
			ST_OUT: begin
				ctl.add_op = ADD_OUT;
				if (sts.out_free) begin
					ctl.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/joint_pd_drive_plant_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joint_pd_drive_plant_step
// PD joint drive with an explicit Euler plant, one joint tick per item.
// ----------------------------------------------------------------------------
// Each item advances one joint: PD torque clamped to the joint's limit (zero
// without a command), viscous damping, Euler update of velocity and position,
// and a position clamp that zeroes velocity. All arithmetic runs on one shared
// multiplier and one saturating adder under a small sequencer that takes a new
// item only when idle. A commanded item runs every step, one without a command
// starts at the damping product, and a joint index beyond the table goes to
// the output step. The result sits in an output register; the sequencer holds
// in its last step only while that register is still occupied. Joint state is
// reset to the initial pose at once, with no clearing pass.
// ----------------------------------------------------------------------------
module joint_pd_drive_plant_step
	import jpd_pkg::*;
#(
	parameter int NUM_JOINTS = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [31:0] cfg_data,
	jpd_in_if.sink      cmd,
	jpd_out_if.source   res
);

	localparam int JW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;

	logic [31:0]        visc_q;
	logic [31:0]        asg_q;
	logic [31:0]        ts_q;

	logic signed [31:0] pos_arr_q [NUM_JOINTS];
	logic signed [31:0] vel_arr_q [NUM_JOINTS];

	logic [3:0]         joint_q;
	logic               valid_q;
	logic               in_range_q;
	logic signed [31:0] tp_q;
	logic signed [31:0] tv_q;
	logic signed [31:0] ff_q;
	logic [31:0]        kp_q;
	logic [31:0]        kd_q;
	logic signed [31:0] pos_q;
	logic signed [31:0] vel_q;
	logic signed [31:0] tmp_q;
	logic signed [31:0] tau_q;
	logic signed [63:0] acc_q;

	logic               res_valid_q;
	logic [3:0]         slot_q;
	logic [2:0]         mode_q;
	logic signed [31:0] pos_hw_q;
	logic signed [31:0] vel_out_q;
	logic signed [31:0] tau_out_q;

	ctl_t               ctl;
	sts_t               sts;
	logic               accept;
	logic               in_range;
	logic [JW-1:0]      idx_in;
	logic [JW-1:0]      idx_q;

	logic signed [31:0] mul_a;
	logic [31:0]        mul_b;
	logic signed [63:0] add_a;
	logic signed [63:0] add_b;
	logic               sub;
	logic signed [63:0] prod;
	logic signed [64:0] sum;
	logic signed [31:0] sum_sat;
	logic signed [63:0] prod_sh16;
	logic signed [63:0] prod_sh32;

	kind_t              kind;
	logic signed [31:0] off;
	logic signed [31:0] lim;
	logic signed [63:0] tmax;

	assign in_range = ({1'b0, cmd.joint} < 5'(NUM_JOINTS));
	assign idx_in   = cmd.joint[JW-1:0];
	assign idx_q    = joint_q[JW-1:0];
	assign accept   = cmd.valid && ctl.idle;

	assign cmd.ready = ctl.idle;

	assign sts.start     = cmd.valid;
	assign sts.cmd_valid = cmd.cmd_valid;
	assign sts.in_range  = in_range;
	assign sts.out_free  = !res_valid_q || res.ready;

	jpd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.ctl    (ctl)
	);

	// per-joint constants
	assign kind = kind_of(joint_q);
	assign off  = slot_offset(slot_of(joint_q));
	assign lim  = kind_lim(kind);
	assign tmax = {32'd0, kind_tau(kind)};

	// floor of the product by 2^16 and 2^32
	assign prod_sh16 = {{16{prod[63]}}, prod[63:16]};
	assign prod_sh32 = {{32{prod[63]}}, prod[63:32]};

	always_comb begin
		case (ctl.mul_op)
			MUL_KP: begin
				mul_a = tmp_q;
				mul_b = kp_q;
			end
			MUL_KD: begin
				mul_a = tmp_q;
				mul_b = kd_q;
			end
			MUL_VISC: begin
				mul_a = vel_q;
				mul_b = visc_q;
			end
			MUL_ASG: begin
				mul_a = tmp_q;
				mul_b = asg_q;
			end
			MUL_TS: begin
				mul_a = vel_q;
				mul_b = ts_q;
			end
			default: begin
				mul_a = tmp_q;
				mul_b = kp_q;
			end
		endcase
	end

	always_comb begin
		add_a = {{32{pos_q[31]}}, pos_q};
		add_b = {{32{off[31]}}, off};
		sub   = 1'b0;
		case (ctl.add_op)
			ADD_EP: begin
				add_a = {{32{tp_q[31]}}, tp_q};
				add_b = {{32{tmp_q[31]}}, tmp_q};
				sub   = 1'b1;
			end
			ADD_EV: begin
				add_a = {{32{tv_q[31]}}, tv_q};
				add_b = {{32{vel_q[31]}}, vel_q};
				sub   = 1'b1;
			end
			ADD_TKD: begin
				add_a = acc_q;
				add_b = prod_sh16;
			end
			ADD_FF: begin
				add_a = acc_q;
				add_b = {{32{ff_q[31]}}, ff_q};
			end
			ADD_NET: begin
				add_a = {{32{tau_q[31]}}, tau_q};
				add_b = prod_sh16;
				sub   = 1'b1;
			end
			ADD_VEL: begin
				add_a = {{32{vel_q[31]}}, vel_q};
				add_b = prod_sh32;
			end
			ADD_POS: begin
				add_a = {{32{pos_q[31]}}, pos_q};
				add_b = prod_sh32;
			end
			default: begin
			end
		endcase
	end

	jpd_alu u_alu (
		.clk     (clk),
		.mul_en  (ctl.mul_en),
		.mul_a   (mul_a),
		.mul_b   (mul_b),
		.add_a   (add_a),
		.add_b   (add_b),
		.sub     (sub),
		.prod    (prod),
		.sum     (sum),
		.sum_sat (sum_sat)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			visc_q <= VISCOUS_RST;
			asg_q  <= ACCEL_RST;
			ts_q   <= TSTEP_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_VISCOUS: visc_q <= cfg_data;
				REG_ACCEL:   asg_q  <= cfg_data;
				REG_TSTEP:   ts_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// joint state, written back when the result is issued
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_JOINTS; i++) begin
				pos_arr_q[i] <= kind_init(kind_of(4'(i)));
				vel_arr_q[i] <= '0;
			end
		end else if (ctl.finish && in_range_q) begin
			pos_arr_q[idx_q] <= pos_q;
			vel_arr_q[idx_q] <= vel_q;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			joint_q    <= cmd.joint;
			valid_q    <= cmd.cmd_valid;
			in_range_q <= in_range;
			tp_q       <= cmd.target_pos;
			tv_q       <= cmd.target_vel;
			ff_q       <= cmd.torque_ff;
			kp_q       <= cmd.prop_gain;
			kd_q       <= cmd.deriv_gain;
			tau_q      <= '0;
			if (in_range) begin
				pos_q <= pos_arr_q[idx_in];
				vel_q <= vel_arr_q[idx_in];
			end
		end else begin
			case (ctl.add_op)
				ADD_PHW, ADD_EP, ADD_EV, ADD_NET: tmp_q <= sum_sat;
				ADD_TKD, ADD_FF:                  acc_q <= sum[63:0];
				ADD_VEL:                          vel_q <= sum_sat;
				ADD_POS:                          pos_q <= sum_sat;
				default: begin
				end
			endcase
			if (ctl.acc_load) begin
				acc_q <= prod_sh16;
			end
			if (ctl.clamp_tau) begin
				if (acc_q > tmax) begin
					tau_q <= tmax[31:0];
				end else if (acc_q < -tmax) begin
					tau_q <= -tmax[31:0];
				end else begin
					tau_q <= acc_q[31:0];
				end
			end
			// hitting a joint stop kills the velocity
			if (ctl.clamp_pos) begin
				if (pos_q > lim) begin
					pos_q <= lim;
					vel_q <= '0;
				end else if (pos_q < -lim) begin
					pos_q <= -lim;
					vel_q <= '0;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ctl.finish) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.finish) begin
			mode_q <= valid_q ? MODE_ACTIVE : MODE_IDLE;
			if (in_range_q) begin
				slot_q    <= slot_of(joint_q);
				pos_hw_q  <= sum_sat;
				vel_out_q <= vel_q;
				tau_out_q <= tau_q;
			end else begin
				slot_q    <= '0;
				pos_hw_q  <= '0;
				vel_out_q <= '0;
				tau_out_q <= '0;
			end
		end
	end

	assign res.valid          = res_valid_q;
	assign res.hw_slot        = slot_q;
	assign res.motor_mode     = mode_q;
	assign res.pos_hw         = pos_hw_q;
	assign res.vel_out        = vel_out_q;
	assign res.torque_applied = tau_out_q;

endmodule

// ===== tb/tb_joint_pd_drive_plant_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_joint_pd_drive_plant_step
// Self-checking bench for the joint PD drive with its Euler plant.
// ----------------------------------------------------------------------------
// An in-bench model of the twelve joints keeps its own copy of position,
// velocity and the plant registers. It predicts the result of every accepted
// command item, and each result taken from the block is compared field by
// field with the oldest prediction. Stimulus runs a few directed ticks, then
// tracking runs and random items under several plant settings, with random
// sender bursts, receiver stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_joint_pd_drive_plant_step;
	import jpd_pkg::*;

	localparam int NUM_JOINTS  = 12;
	localparam int TAIL_CYCLES = 24;
	localparam int STALL_LIMIT = 4000;
	localparam int MAX_REPORTS = 10;

	localparam int          Q_ONE    = 65536;
	localparam int          Q_MAX    = 32'sh7fff_ffff;
	localparam int          Q_MIN    = 32'sh8000_0000;
	localparam int unsigned GAIN_MAX = 32'hffff_ffff;

	// index past the register file, writes to it must be ignored
	localparam logic [1:0] REG_UNUSED = 2'd3;

	typedef enum int {
		RX_OPEN,
		RX_COIN,
		RX_THREE_OF_FOUR,
		RX_SPARSE
	} rx_mode_t;

	typedef struct packed {
		logic [3:0]  joint;
		logic        cmd_valid;
		int          target_pos;
		int          target_vel;
		int          torque_ff;
		int unsigned prop_gain;
		int unsigned deriv_gain;
	} joint_cmd_t;

	typedef struct packed {
		logic [3:0] hw_slot;
		logic [2:0] motor_mode;
		int         pos_hw;
		int         vel_out;
		int         torque_applied;
	} joint_tick_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_idx;
	logic [31:0] cfg_data;

	jpd_in_if  cmd_ch ();
	jpd_out_if res_ch ();

	joint_pd_drive_plant_step #(
		.NUM_JOINTS(NUM_JOINTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.cmd(cmd_ch),
		.res(res_ch)
	);

	always #5 clk = ~clk;

	// plant model state and registers
	int          plant_pos [16];
	int          plant_vel [16];
	int unsigned visc_gain;
	int unsigned accel_gain;
	int unsigned step_gain;

	joint_tick_t pending_ticks [$];
	int          error_count = 0;
	int          burst_left = 0;
	bit          sender_steady = 1'b0;
	int          hold_cycles = 0;

	// ------------------------------------------------------------------------
	// plant model
	// ------------------------------------------------------------------------
	function automatic int sat32(input longint v);
		if (v > longint'(Q_MAX))
			return Q_MAX;
		if (v < longint'(Q_MIN))
			return Q_MIN;
		return int'(v);
	endfunction

	// exact product, then floor division by 2^s
	function automatic longint scale_by(input int v, input int unsigned g, input int s);
		longint a;
		longint b;
		a = v;
		b = g;
		return (a * b) >>> s;
	endfunction

	function automatic logic [3:0] slot_for(input logic [3:0] j);
		logic [3:0] s;
		case (j)
			4'd0:    s = 4'd0;
			4'd1:    s = 4'd1;
			4'd2:    s = 4'd2;
			4'd3:    s = 4'd4;
			4'd4:    s = 4'd5;
			4'd5:    s = 4'd6;
			4'd6:    s = 4'd8;
			4'd7:    s = 4'd9;
			4'd8:    s = 4'd10;
			4'd9:    s = 4'd12;
			4'd10:   s = 4'd13;
			4'd11:   s = 4'd14;
			4'd12:   s = 4'd3;
			4'd13:   s = 4'd7;
			4'd14:   s = 4'd11;
			default: s = 4'd15;
		endcase
		return s;
	endfunction

	function automatic int offset_for(input logic [3:0] s);
		int o;
		case (s)
			4'd0, 4'd8:   o = -Q_OFF_SMALL;
			4'd4, 4'd12:  o = Q_OFF_SMALL;
			4'd1, 4'd5:   o = -Q_OFF_HALF;
			4'd9, 4'd13:  o = Q_OFF_HALF;
			4'd2, 4'd6:   o = Q_OFF_KNEE;
			4'd10, 4'd14: o = -Q_OFF_KNEE;
			default:      o = 0;
		endcase
		return o;
	endfunction

	task automatic reset_plant();
		visc_gain = VISCOUS_RST;
		accel_gain = ACCEL_RST;
		step_gain = TSTEP_RST;
		for (int i = 0; i < 16; i++) begin
			case (kind_t'(i % 3))
				KIND_THIGH: plant_pos[i] = Q_THIGH_INIT;
				KIND_CALF:  plant_pos[i] = -Q_CALF_LIM;
				default:    plant_pos[i] = 0;
			endcase
			plant_vel[i] = 0;
		end
	endtask

	function automatic joint_tick_t advance_joint(input joint_cmd_t c);
		joint_tick_t r;
		kind_t       kind;
		logic [3:0]  slot;
		int          off;
		int          lim;
		int          tmax;
		int          pos;
		int          vel;
		int          tau;
		int          pos_hw;
		int          net;
		longint      t;
		r = '0;
		r.motor_mode = c.cmd_valid ? MODE_ACTIVE : MODE_IDLE;
		if (c.joint >= NUM_JOINTS)
			return r;
		kind = kind_t'(c.joint % 3);
		slot = slot_for(c.joint);
		off = offset_for(slot);
		case (kind)
			KIND_ABAD: begin
				lim = Q_ABAD_LIM;
				tmax = Q_TAU_SMALL;
			end
			KIND_THIGH: begin
				lim = Q_THIGH_LIM;
				tmax = Q_TAU_SMALL;
			end
			default: begin
				lim = Q_CALF_LIM;
				tmax = Q_TAU_LARGE;
			end
		endcase
		pos = plant_pos[c.joint];
		vel = plant_vel[c.joint];
		tau = 0;
		if (c.cmd_valid) begin
			pos_hw = sat32(longint'(pos) + longint'(off));
			t = scale_by(sat32(longint'(c.target_pos) - longint'(pos_hw)), c.prop_gain, 16)
				+ scale_by(sat32(longint'(c.target_vel) - longint'(vel)), c.deriv_gain, 16)
				+ longint'(c.torque_ff);
			if (t > longint'(tmax))
				t = longint'(tmax);
			if (t < -longint'(tmax))
				t = -longint'(tmax);
			tau = int'(t);
		end
		net = sat32(longint'(tau) - scale_by(vel, visc_gain, 16));
		vel = sat32(longint'(vel) + scale_by(net, accel_gain, 32));
		pos = sat32(longint'(pos) + scale_by(vel, step_gain, 32));
		if (pos > lim) begin
			pos = lim;
			vel = 0;
		end
		if (pos < -lim) begin
			pos = -lim;
			vel = 0;
		end
		plant_pos[c.joint] = pos;
		plant_vel[c.joint] = vel;
		r.hw_slot = slot;
		r.pos_hw = sat32(longint'(pos) + longint'(off));
		r.vel_out = vel;
		r.torque_applied = tau;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// result checking
	// ------------------------------------------------------------------------
	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			error_count++;
			if (error_count <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : result_check
		joint_tick_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_ticks.size() == 0) begin
				error_count++;
				if (error_count <= MAX_REPORTS)
					$display("%0t: result item with nothing outstanding", $time);
			end else begin
				want = pending_ticks.pop_front();
				check_field("hw_slot", want.hw_slot, res_ch.hw_slot);
				check_field("motor_mode", want.motor_mode, res_ch.motor_mode);
				check_field("pos_hw", want.pos_hw, res_ch.pos_hw);
				check_field("vel_out", want.vel_out, res_ch.vel_out);
				check_field("torque_applied", want.torque_applied, res_ch.torque_applied);
			end
		end
	end

	// ------------------------------------------------------------------------
	// receiver: rotating stall pattern, plus a hold-off on request
	// ------------------------------------------------------------------------
	initial begin : receiver
		rx_mode_t rx_mode;
		int       rx_cycle;
		rx_mode = RX_OPEN;
		rx_cycle = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			rx_cycle++;
			if (hold_cycles > 0) begin
				hold_cycles--;
				res_ch.ready <= 1'b0;
			end else begin
				case (rx_mode)
					RX_OPEN:          res_ch.ready <= 1'b1;
					RX_COIN:          res_ch.ready <= 1'($urandom_range(0, 1));
					RX_THREE_OF_FOUR: res_ch.ready <= (rx_cycle % 4) != 0;
					default:          res_ch.ready <= $urandom_range(0, 3) == 0;
				endcase
			end
			if (rx_cycle % 53 == 0)
				rx_mode = rx_mode_t'($urandom_range(0, 3));
		end
	end

	// ------------------------------------------------------------------------
	// watchdog: cycles in which no item moves on either side
	// ------------------------------------------------------------------------
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb_joint_pd_drive_plant_step: done, errors");
		$finish;
	end

	// ------------------------------------------------------------------------
	// sender side
	// ------------------------------------------------------------------------
	task automatic pace_sender();
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			case ($urandom_range(0, 7))
				0, 1, 2: gap = 0;
				7:       gap = $urandom_range(10, 24);
				default: gap = $urandom_range(1, 6);
			endcase
			if (gap > 0 && !sender_steady) begin
				cmd_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
	endtask

	task automatic send_cmd(input joint_cmd_t c);
		pace_sender();
		cmd_ch.valid <= 1'b1;
		cmd_ch.joint <= c.joint;
		cmd_ch.cmd_valid <= c.cmd_valid;
		cmd_ch.target_pos <= c.target_pos;
		cmd_ch.target_vel <= c.target_vel;
		cmd_ch.torque_ff <= c.torque_ff;
		cmd_ch.prop_gain <= c.prop_gain;
		cmd_ch.deriv_gain <= c.deriv_gain;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		pending_ticks.push_back(advance_joint(c));
	endtask

	// stop offering and wait until every predicted tick has come back
	task automatic drain();
		cmd_ch.valid <= 1'b0;
		while (pending_ticks.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [1:0] idx, input logic [31:0] data);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_VISCOUS: visc_gain = data;
			REG_ACCEL:   accel_gain = data;
			REG_TSTEP:   step_gain = data;
			default:     ;
		endcase
	endtask

	task automatic set_plant(input int unsigned visc, input int unsigned accel,
			input int unsigned tstep);
		drain();
		cfg_write(REG_VISCOUS, visc);
		cfg_write(REG_ACCEL, accel);
		cfg_write(REG_TSTEP, tstep);
	endtask

	function automatic joint_cmd_t make_cmd(input logic [3:0] j, input logic v,
			input int tp, input int tv, input int ff, input int unsigned kp,
			input int unsigned kd);
		joint_cmd_t c;
		c.joint = j;
		c.cmd_valid = v;
		c.target_pos = tp;
		c.target_vel = tv;
		c.torque_ff = ff;
		c.prop_gain = kp;
		c.deriv_gain = kd;
		return c;
	endfunction

	// mostly plausible commands, with a share of full-range values per field
	function automatic joint_cmd_t rand_cmd();
		joint_cmd_t c;
		c.joint = 4'(($urandom_range(0, 15) == 0) ? $urandom_range(0, 15)
			: $urandom_range(0, NUM_JOINTS - 1));
		c.cmd_valid = $urandom_range(0, 7) != 0;
		c.target_pos = ($urandom_range(0, 9) == 0) ? $urandom
			: int'($urandom_range(0, 8 * Q_ONE)) - 4 * Q_ONE;
		c.target_vel = ($urandom_range(0, 9) == 0) ? $urandom
			: int'($urandom_range(0, 40 * Q_ONE)) - 20 * Q_ONE;
		c.torque_ff = ($urandom_range(0, 9) == 0) ? $urandom
			: int'($urandom_range(0, 80 * Q_ONE)) - 40 * Q_ONE;
		c.prop_gain = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 200 * Q_ONE);
		c.deriv_gain = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 10 * Q_ONE);
		return c;
	endfunction

	// tracking runs drive one joint for several ticks, now and then nudging the target
	task automatic run_random(input int n_items);
		int         sent;
		int         run_len;
		joint_cmd_t c;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 3) != 0) begin
				c = rand_cmd();
				c.joint = 4'($urandom_range(0, NUM_JOINTS - 1));
				c.cmd_valid = 1'b1;
				run_len = $urandom_range(3, 10);
				repeat (run_len) begin
					send_cmd(c);
					if ($urandom_range(0, 3) == 0)
						c.target_pos = c.target_pos + int'($urandom_range(0, Q_ONE)) - Q_ONE / 2;
				end
				sent += run_len;
			end else begin
				send_cmd(rand_cmd());
				sent++;
			end
		end
		drain();
	endtask

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------
	task automatic test_reset_pose();
		send_cmd(make_cmd(4'd0, 1'b0, 0, 0, 0, 0, 0));
		send_cmd(make_cmd(4'd1, 1'b0, 0, 0, 0, 0, 0));
		send_cmd(make_cmd(4'd2, 1'b0, 0, 0, 0, 0, 0));
		// joints beyond the table leave the state alone and report zeros apart from the mode
		send_cmd(make_cmd(4'd12, 1'b1, Q_MAX, Q_MAX, Q_MAX, GAIN_MAX, GAIN_MAX));
		send_cmd(make_cmd(4'd15, 1'b0, Q_MIN, Q_MIN, Q_MIN, GAIN_MAX, GAIN_MAX));
		drain();
	endtask

	task automatic test_torque_clamp();
		send_cmd(make_cmd(4'd0, 1'b1, Q_MAX, Q_MAX, Q_MAX, GAIN_MAX, GAIN_MAX));
		// position error saturates on the low side
		send_cmd(make_cmd(4'd1, 1'b1, Q_MIN, Q_MIN, Q_MIN, GAIN_MAX, GAIN_MAX));
		send_cmd(make_cmd(4'd2, 1'b1, 0, 0, 50 * Q_ONE, 0, 0));
		send_cmd(make_cmd(4'd2, 1'b1, 0, 0, -60 * Q_ONE, 0, 0));
		send_cmd(make_cmd(4'd3, 1'b1, 0, 0, 0, 0, 0));
		send_cmd(make_cmd(4'd11, 1'b1, 0, 0, 0, 10 * Q_ONE, Q_ONE));
		drain();
	endtask

	task automatic test_position_clamp();
		// unit step and gain, no damping: one tick runs past either limit
		set_plant(0, GAIN_MAX, GAIN_MAX);
		send_cmd(make_cmd(4'd4, 1'b1, 0, 0, Q_MAX, 0, 0));
		send_cmd(make_cmd(4'd4, 1'b1, 0, 0, Q_MAX, 0, 0));
		send_cmd(make_cmd(4'd5, 1'b1, 0, 0, Q_MIN, 0, 0));
		send_cmd(make_cmd(4'd5, 1'b1, 0, 0, Q_MIN, 0, 0));
		send_cmd(make_cmd(4'd6, 1'b1, 0, 0, Q_MIN, 0, 0));
		send_cmd(make_cmd(4'd6, 1'b0, 0, 0, 0, 0, 0));
		set_plant(VISCOUS_RST, ACCEL_RST, TSTEP_RST);
	endtask

	task automatic test_default_plant();
		run_random(120);
	endtask

	task automatic test_backpressure();
		drain();
		sender_steady = 1'b1;
		hold_cycles = 300;
		repeat (24) send_cmd(rand_cmd());
		sender_steady = 1'b0;
		drain();
	endtask

	task automatic test_plant_settings();
		set_plant(0, GAIN_MAX, GAIN_MAX);
		cfg_write(REG_UNUSED, $urandom);
		run_random(60);
		set_plant(GAIN_MAX, 0, 0);
		run_random(40);
		// heavy damping with unit gains drives the net torque into saturation
		set_plant(GAIN_MAX, GAIN_MAX, GAIN_MAX);
		run_random(40);
		set_plant($urandom_range(0, 2 * Q_ONE), $urandom, $urandom_range(0, 32'h1999_9999));
		cfg_write(REG_UNUSED, $urandom);
		run_random(80);
		set_plant(VISCOUS_RST, ACCEL_RST, TSTEP_RST);
		run_random(60);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = REG_VISCOUS;
		cfg_data = '0;
		cmd_ch.valid = 1'b0;
		cmd_ch.joint = '0;
		cmd_ch.cmd_valid = 1'b0;
		cmd_ch.target_pos = '0;
		cmd_ch.target_vel = '0;
		cmd_ch.torque_ff = '0;
		cmd_ch.prop_gain = '0;
		cmd_ch.deriv_gain = '0;
		reset_plant();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_pose();
		test_torque_clamp();
		test_position_clamp();
		test_default_plant();
		test_backpressure();
		test_plant_settings();

		drain();
		if (error_count == 0)
			$display("tb_joint_pd_drive_plant_step: done, clean");
		else
			$display("tb_joint_pd_drive_plant_step: done, errors");
		$finish;
	end

endmodule
